FILE: rtl/core/btd_pkg.sv
// Shared types and sizing constants for the byte trie dictionary.
// No dependencies; every other file in rtl/core imports this package.
package btd_pkg;

    // Pool and alphabet sizing
    localparam int NODE_COUNT = 256;
    localparam int ALPHABET   = 256;

    localparam int NODE_W    = $clog2(NODE_COUNT);
    localparam int SYM_W     = $clog2(ALPHABET);
    localparam int ADDR_W    = NODE_W + SYM_W;
    localparam int COUNT_W   = $clog2(NODE_COUNT + 1);
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Fixed field widths of the channels
    localparam int SYMBOL_FW = 8;
    localparam int USED_FW   = 9;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [SYMBOL_FW-1:0] symbol;
        logic                 has_symbol;
        logic                 last;
    } t_in_beat;

    typedef struct packed {
        logic               found;
        logic               pool_full;
        logic [USED_FW-1:0] nodes_used;
    } t_out_beat;

    // One child slot: pointer to the child node plus the word mark of that child.
    // Every non-root node has exactly one parent slot, so its mark lives there.
    typedef struct packed {
        logic              mark;
        logic [NODE_W-1:0] ptr;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        t_entry            wdata;
    } t_mem_req;

endpackage

FILE: rtl/core/btd_child_store.sv
// Child slot memory of the trie with its post-reset clearing sweep.
// Depends on btd_pkg.
module btd_child_store import btd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_entry   o_rdata,
    output logic     o_busy
);

    t_entry            r_mem [MEM_DEPTH];
    t_entry            r_rdata;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Sweep every slot to zero after reset, one slot a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

FILE: rtl/core/byte_trie_dictionary.sv
// Top level of the byte trie dictionary: walk sequencer, pool counter, result register.
// Depends on btd_pkg and btd_child_store.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+------------------------------
//   in      | into      | t_in_beat   | i_in_valid  / o_in_stall
//   out     | out of    | t_out_beat  | o_out_valid / i_out_stall
//
// A character beat is accepted in S_IDLE, which issues the slot read; S_LOOK then
// resolves the read data and, on a missing child during insert, writes the new slot.
// A last beat then passes through S_FIN to emit the result and write the word mark.
// Beats without a character, or after a failed walk, skip the slot read.
// After reset all NODE_COUNT*ALPHABET slots of the child memory are swept to zero;
// o_in_stall stays high for that whole sweep.
// A result waits in the output register while o_out_valid is stalled; the
// next beat is still taken, and only a further last beat holds until it drains.
module byte_trie_dictionary import btd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_cur, n_cur;          // node reached so far
    logic               r_cur_mark, n_cur_mark; // word mark of that node
    logic [ADDR_W-1:0]  r_slot, n_slot;        // parent slot of the current node
    logic [ADDR_W-1:0]  r_addr, n_addr;        // slot being looked up
    logic [COUNT_W-1:0] r_free, n_free;        // next free node, also nodes in use
    logic               r_failed, n_failed;
    logic               r_ovf, n_ovf;
    logic               r_root_mark, n_root_mark;
    logic               r_action, n_action;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    t_mem_req           mem_req;
    t_entry             mem_rdata;
    logic               mem_busy;

    logic               in_acc;
    logic               out_free;
    logic               cur_word;

    btd_child_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    assign o_in_stall = (r_state != S_IDLE) || mem_busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    // The root keeps its mark in a flop; any other node's mark came with its slot
    assign cur_word   = (r_cur == '0) ? r_root_mark : r_cur_mark;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_cur_mark  = r_cur_mark;
        n_slot      = r_slot;
        n_addr      = r_addr;
        n_free      = r_free;
        n_failed    = r_failed;
        n_ovf       = r_ovf;
        n_root_mark = r_root_mark;
        n_action    = r_action;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_req     = '0;

        // Drain the output register when its beat is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action = i_in_data.action;
                    n_last   = i_in_data.last;
                    if (i_in_data.has_symbol && !r_failed) begin
                        n_addr        = {r_cur, i_in_data.symbol[SYM_W-1:0]};
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = n_addr;
                        n_state       = S_LOOK;
                    end else if (i_in_data.last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOOK: begin
                if (mem_rdata.ptr != '0) begin
                    // Follow the existing child
                    n_cur      = mem_rdata.ptr;
                    n_cur_mark = mem_rdata.mark;
                    n_slot     = r_addr;
                end else if (r_action == ACT_SEARCH) begin
                    n_failed = 1'b1;
                end else if (r_free >= COUNT_W'(NODE_COUNT)) begin
                    n_ovf    = 1'b1;
                    n_failed = 1'b1;
                end else begin
                    // Allocate the next node and hang it on this slot
                    mem_req.wr_en     = 1'b1;
                    mem_req.addr      = r_addr;
                    mem_req.wdata.ptr = r_free[NODE_W-1:0];
                    n_cur             = r_free[NODE_W-1:0];
                    n_cur_mark        = 1'b0;
                    n_slot            = r_addr;
                    n_free            = r_free + 1'b1;
                end
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.found      = (r_action == ACT_SEARCH) && !r_failed && cur_word;
                    n_out.pool_full  = (r_action == ACT_INSERT) && r_ovf;
                    n_out.nodes_used = USED_FW'(n_free);
                    if ((r_action == ACT_INSERT) && !r_failed) begin
                        if (r_cur == '0) begin
                            n_root_mark = 1'b1;
                        end else begin
                            mem_req.wr_en      = 1'b1;
                            mem_req.addr       = r_slot;
                            mem_req.wdata.mark = 1'b1;
                            mem_req.wdata.ptr  = r_cur;
                        end
                    end
                    // Return the walk to the root for the next string
                    n_cur      = '0;
                    n_cur_mark = 1'b0;
                    n_failed   = 1'b0;
                    n_ovf      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_cur_mark  <= 1'b0;
            r_free      <= COUNT_W'(1);
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_root_mark <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_cur_mark  <= n_cur_mark;
            r_free      <= n_free;
            r_failed    <= n_failed;
            r_ovf       <= n_ovf;
            r_root_mark <= n_root_mark;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_addr   <= n_addr;
        r_action <= n_action;
        r_last   <= n_last;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sim/tb_byte_trie_dictionary.sv
// Self-checking bench for byte_trie_dictionary: insert and search strings, pool exhaustion,
// mixed-action strings and back-pressure. Depends on btd_pkg and the RTL top level only;
// expected results come from a trie mirror kept inside this module.
module tb_byte_trie_dictionary import btd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BEATS = 1250;
    // Allow several times the clearing sweep after reset with no beat moving.
    localparam int QUIET_LIMIT  = 250_000;
    localparam int TAIL_CYCLES  = 30;
    localparam int SQUEEZE_AT   = 300;
    localparam int SQUEEZE_LEN  = 500;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;
    logic      out_stall = 1'b0;

    byte_trie_dictionary dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_beat),
        .i_out_stall (out_stall)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Trie mirror: child pointers, word marks and the walk of the open string
    // ------------------------------------------------------------------
    bit [7:0]  kid_ptr [65536];   // {node, symbol} -> child, 0 means no child
    bit        word_end [256];
    bit [7:0]  cur_node   = '0;
    bit [8:0]  used_nodes = 9'd1; // the root is always allocated
    bit        walk_dead  = 1'b0;
    bit        pool_out   = 1'b0;

    t_out_beat answers_due [$];
    t_in_beat  beat_queue  [$];

    // Step one character down the trie; allocate on a missing child when inserting.
    function automatic void trie_walk(bit seek, bit [7:0] sym);
        bit [7:0] nxt;
        if (walk_dead) return;
        nxt = kid_ptr[{cur_node, sym}];
        if (nxt == 8'd0) begin
            if (seek) begin
                walk_dead = 1'b1;
                return;
            end
            if (used_nodes >= NODE_COUNT) begin
                pool_out  = 1'b1;
                walk_dead = 1'b1;
                return;
            end
            nxt = used_nodes[7:0];
            kid_ptr[{cur_node, sym}] = nxt;
            used_nodes++;
        end
        cur_node = nxt;
    endfunction

    // Work out the result, if any, that one accepted beat causes.
    function automatic void trie_predict(t_in_beat b);
        t_out_beat want;
        if (b.has_symbol) trie_walk(b.action == ACT_SEARCH, b.symbol);
        if (!b.last) return;
        want = '0;
        if (b.action == ACT_SEARCH) begin
            want.found = !walk_dead && word_end[cur_node];
        end else begin
            // a walk that failed, for whatever reason, marks no word
            if (!walk_dead) word_end[cur_node] = 1'b1;
            want.pool_full = pool_out;
        end
        want.nodes_used = used_nodes;
        answers_due.push_back(want);
        cur_node  = '0;
        walk_dead = 1'b0;
        pool_out  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_beat(logic act, logic [7:0] sym, logic has, logic fin);
        t_in_beat b;
        b.action     = act;
        b.symbol     = sym;
        b.has_symbol = has;
        b.last       = fin;
        beat_queue.push_back(b);
    endfunction

    // Character k of a word sits in text[8k+7:8k]; an empty word is one beat with no character.
    function automatic void push_word(logic act, logic [63:0] text, int len);
        if (len == 0) push_beat(act, 8'($urandom), 1'b0, 1'b1);
        for (int k = 0; k < len; k++) push_beat(act, text[8*k +: 8], 1'b1, k == len - 1);
    endfunction

    // Draw a word: half the time from a narrow alphabet so that paths share prefixes.
    function automatic void make_word(output logic [63:0] text, output int len);
        bit narrow;
        narrow = ($urandom_range(0, 1) == 0);
        len    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        text   = '0;
        for (int k = 0; k < len; k++)
            text[8*k +: 8] = narrow ? 8'($urandom_range(8'h41, 8'h44)) : 8'($urandom);
    endfunction

    // Idle draw per beat, with stretches of back-to-back traffic in between.
    function automatic int pick_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 80);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------
    // Handshake bookkeeping shared between the clocked processes
    // ------------------------------------------------------------------
    bit in_fire   = 1'b0;
    bit out_fire  = 1'b0;
    int beats_in  = 0;
    int beats_total;
    int fail_count = 0;
    int results_seen = 0;
    int search_hits  = 0;
    int search_miss  = 0;
    int full_flags   = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Driver: present queued beats at the falling edge, hold while stalled
    // ------------------------------------------------------------------
    int in_gap      = 0;
    int in_run_left = 0;
    bit in_calm     = 1'b0;
    bit in_busy     = 1'b0;

    always @(negedge clk) begin
        if (in_fire) begin
            in_fire = 1'b0;
            in_busy = 1'b0;
            in_gap  = pick_wait(in_run_left, in_calm);
        end
        if (!in_busy && rst_n) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (beat_queue.size() != 0) begin
                in_beat <= beat_queue.pop_front();
                in_busy = 1'b1;
            end
        end
        // one update of valid per edge, so a back-to-back beat keeps it high
        in_valid <= in_busy;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after a result, plus one long hold-off to fill the block
    // ------------------------------------------------------------------
    int  out_wait      = 0;
    int  out_run_left  = 0;
    bit  out_calm      = 1'b0;
    int  squeeze_left  = 0;
    bit  squeeze_done  = 1'b0;

    always @(negedge clk) begin : drain
        bit stall_now;
        if (out_fire) begin
            out_fire = 1'b0;
            out_wait = pick_wait(out_run_left, out_calm);
        end
        if (!squeeze_done && beats_in >= SQUEEZE_AT) begin
            squeeze_done = 1'b1;
            squeeze_left = SQUEEZE_LEN;
        end
        stall_now = (squeeze_left != 0) || (out_wait != 0);
        if (squeeze_left != 0) squeeze_left--;
        if (out_wait != 0) out_wait--;
        out_stall <= stall_now;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, predict and compare
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch
        t_out_beat want;
        bit        moved;
        if (rst_n) begin
            moved = 1'b0;
            // predict before checking, so a result never overtakes its own expectation
            if (in_valid && !in_stall) begin
                in_fire = 1'b1;
                beats_in++;
                moved = 1'b1;
                trie_predict(in_beat);
            end
            if (out_valid && !out_stall) begin
                out_fire = 1'b1;
                moved    = 1'b1;
                results_seen++;
                if (answers_due.size() == 0) begin
                    $error("result beat with no expectation waiting: %p", out_beat);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (out_beat.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_beat.found);
                        fail_count++;
                    end
                    if (out_beat.pool_full !== want.pool_full) begin
                        $error("pool_full: expected %0d, got %0d",
                               want.pool_full, out_beat.pool_full);
                        fail_count++;
                    end
                    if (out_beat.nodes_used !== want.nodes_used) begin
                        $error("nodes_used: expected %0d, got %0d",
                               want.nodes_used, out_beat.nodes_used);
                        fail_count++;
                    end
                    if (want.found) search_hits++;
                    if (want.pool_full) full_flags++;
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] lex_text [$];
        int          lex_len  [$];
        logic [63:0] text;
        int          len;
        int          pick;
        int          idx;
        int          n;
        int          planned;

        // Directed: empty string, byte extremes, prefixes, misses, mixed actions, blank beats
        push_word(ACT_SEARCH, '0, 0);                 // empty string not yet stored
        push_word(ACT_INSERT, '0, 0);                 // mark the root
        push_word(ACT_SEARCH, '0, 0);                 // now found
        push_word(ACT_INSERT, 64'hFF00, 2);
        push_word(ACT_SEARCH, 64'hFF00, 2);           // stored word
        push_word(ACT_SEARCH, 64'h00, 1);             // prefix only, no mark
        push_word(ACT_SEARCH, 64'hFF, 1);             // missing child
        push_beat(ACT_SEARCH, 8'h00, 1'b1, 1'b0);     // search walks, insert ends and allocates
        push_beat(ACT_INSERT, 8'hAA, 1'b1, 1'b1);
        push_beat(ACT_SEARCH, 8'h55, 1'b1, 1'b0);     // search fails, insert must not mark
        push_beat(ACT_INSERT, 8'h01, 1'b1, 1'b1);
        push_word(ACT_SEARCH, 64'h0155, 2);
        push_beat(ACT_INSERT, 8'h12, 1'b1, 1'b0);     // blank beat in the middle of a string
        push_beat(ACT_INSERT, 8'hFF, 1'b0, 1'b0);
        push_beat(ACT_INSERT, 8'h34, 1'b1, 1'b1);
        push_beat(ACT_SEARCH, 8'h12, 1'b1, 1'b0);     // string closed by a blank last beat
        push_beat(ACT_SEARCH, 8'h34, 1'b1, 1'b0);
        push_beat(ACT_SEARCH, 8'h00, 1'b0, 1'b1);
        push_beat(ACT_SEARCH, 8'h77, 1'b1, 1'b0);     // beats after a failed walk stay put
        push_beat(ACT_SEARCH, 8'h00, 1'b1, 1'b0);
        push_beat(ACT_SEARCH, 8'hFF, 1'b1, 1'b1);

        lex_text.push_back(64'hFF00);
        lex_len.push_back(2);
        lex_text.push_back(64'h3412);
        lex_len.push_back(2);

        // Random: mostly well-formed strings, so the pool fills and later inserts overflow
        planned = beat_queue.size() + RANDOM_BEATS;
        while (beat_queue.size() < planned) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, lex_text.size() - 1);
            if (pick < 30) begin
                make_word(text, len);
                push_word(ACT_INSERT, text, len);
                lex_text.push_back(text);
                lex_len.push_back(len);
            end else if (pick < 55) begin
                push_word(ACT_SEARCH, lex_text[idx], lex_len[idx]);
            end else if (pick < 65) begin
                // cut a stored word short, or run one character past it
                text = lex_text[idx];
                len  = lex_len[idx];
                if (len < 8 && $urandom_range(0, 1) == 0) begin
                    text[8*len +: 8] = 8'($urandom_range(8'h41, 8'h44));
                    len++;
                end else if (len > 0) begin
                    len = $urandom_range(0, len - 1);
                end
                push_word(ACT_SEARCH, text, len);
            end else if (pick < 75) begin
                make_word(text, len);
                push_word(ACT_SEARCH, text, len);
            end else if (pick < 83) begin
                push_word(ACT_INSERT, lex_text[idx], lex_len[idx]);
            end else if (pick < 91) begin
                // mixed actions with the odd blank beat
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    push_beat(1'($urandom),
                              $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h44))
                                                   : 8'($urandom),
                              $urandom_range(0, 4) != 0, k == n - 1);
            end else begin
                // noise: every field random, then close the string
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    push_beat(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                push_beat(1'($urandom), 8'($urandom), 1'($urandom), 1'b1);
            end
        end
        beats_total = beat_queue.size();

        // hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_in < beats_total || answers_due.size() != 0) @(posedge clk);
        // drain the tail so a stray result still gets caught
        repeat (TAIL_CYCLES) @(posedge clk);

        search_miss = results_seen - search_hits;
        $display("Ran %0d beats giving %0d results; %0d found, %0d not found or inserts.",
                 beats_in, results_seen, search_hits, search_miss);
        $display("Pool reached %0d of %0d nodes; %0d inserts flagged a full pool.",
                 used_nodes, NODE_COUNT, full_flags);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
